@@ hdl/rbq_pkg.sv @@
// Shared types and constants for the reorder buffer queue.
// No dependencies; imported by rbq_ctrl, reorder_buffer_queue and the bench.
package rbq_pkg;

    localparam int DEPTH_DEF     = 32;
    localparam int PAYLOAD_W_DEF = 32;

    localparam int KIND_W = 2;
    localparam int TAG_W  = 5;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 6;
    localparam int OCC_W  = 6;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

    typedef enum logic [KIND_W-1:0] {
        K_ALLOC    = 2'd0,
        K_COMPLETE = 2'd1,
        K_QUERY    = 2'd2,
        K_COMMIT   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_READY = 2'd2,
        ST_BAD_TAG   = 2'd3
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [TAG_W-1:0]   tag;
        logic               entry_ready;
        logic               has_space;
        logic               head_ready;
        logic [OCC_W-1:0]   occupancy;
        logic               commit;
    } t_result;

endpackage

@@ hdl/rbq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rbq_ctrl.sv @@
// Reorder buffer control: valid and ready bits, pointers, count and result register.
// Depends on rbq_pkg; drives the payload RAM ports.
module rbq_ctrl #(
    parameter int DEPTH   = rbq_pkg::DEPTH_DEF,
    parameter int STORE_W = rbq_pkg::DATA_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(DEPTH+1)-1:0]          i_size,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rbq_pkg::KIND_W-1:0]          i_kind,
    input  logic [rbq_pkg::TAG_W-1:0]           i_entry_tag,
    input  logic [rbq_pkg::DATA_W-1:0]          i_inst_payload,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rbq_pkg::t_result                    o_res,
    output logic                                o_ram_we,
    output logic [$clog2(DEPTH)-1:0]            o_ram_waddr,
    output logic [STORE_W-1:0]                  o_ram_wdata,
    output logic                                o_ram_re,
    output logic [$clog2(DEPTH)-1:0]            o_ram_raddr
);
    import rbq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0] r_valid, n_valid;
    logic [DEPTH-1:0] r_ready, n_ready;
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_out_valid;
    t_result          r_res, n_res;

    logic             accept;
    logic [IDX_W-1:0] tag_idx;
    logic             tag_ok;

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] p,
                                                 input logic [CNT_W-1:0] size);
        logic [CNT_W-1:0] n;
        n = CNT_W'(p) + CNT_W'(1);
        return (n >= size) ? '0 : IDX_W'(n);
    endfunction

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign tag_idx    = IDX_W'(int'(i_entry_tag));
    assign tag_ok     = (int'(i_entry_tag) < DEPTH) && r_valid[tag_idx];

    always_comb begin
        n_valid     = r_valid;
        n_ready     = r_ready;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_res       = '0;
        n_res.status = ST_OK;
        o_ram_we    = 1'b0;
        o_ram_re    = 1'b0;
        o_ram_waddr = r_tail;
        o_ram_wdata = i_inst_payload[STORE_W-1:0];
        o_ram_raddr = r_head;

        unique case (t_kind'(i_kind))
            K_ALLOC: begin
                if (r_count >= i_size || r_valid[r_tail]) begin
                    n_res.status = ST_FULL;
                end else begin
                    o_ram_we        = accept;
                    n_valid[r_tail] = 1'b1;
                    n_ready[r_tail] = 1'b0;
                    n_res.tag       = TAG_W'(r_tail);
                    n_count         = r_count + CNT_W'(1);
                    n_tail          = advance(r_tail, i_size);
                end
            end
            K_COMPLETE: begin
                if (!tag_ok || r_ready[tag_idx]) begin
                    n_res.status = ST_BAD_TAG;
                end else begin
                    n_ready[tag_idx] = 1'b1;
                end
            end
            K_QUERY: begin
                if (!tag_ok) begin
                    n_res.status = ST_BAD_TAG;
                end else begin
                    n_res.entry_ready = r_ready[tag_idx];
                end
            end
            K_COMMIT: begin
                if (r_count == '0 || !r_valid[r_head] || !r_ready[r_head]) begin
                    n_res.status = ST_NOT_READY;
                end else begin
                    o_ram_re        = accept;
                    n_res.commit    = 1'b1;
                    n_res.tag       = TAG_W'(r_head);
                    n_valid[r_head] = 1'b0;
                    n_ready[r_head] = 1'b0;
                    n_count         = r_count - CNT_W'(1);
                    n_head          = advance(r_head, i_size);
                end
            end
            default: begin
                n_res.status = ST_OK;
            end
        endcase

        n_res.has_space  = n_count < i_size;
        n_res.head_ready = n_valid[n_head] && n_ready[n_head];
        n_res.occupancy  = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_ready     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid     <= n_valid;
                r_ready     <= n_ready;
                r_head      <= n_head;
                r_tail      <= n_tail;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

@@ hdl/reorder_buffer_queue.sv @@
// Reorder buffer queue: each accepted input beat is registered straight into the result register.
// Throughput one beat per cycle; the result register takes a new beat whenever
// it is empty or being drained, and commit payload comes from the RAM read register.
// Reset clears all valid and ready bits, pointers and count, and sets the size
// register to 32; payload RAM contents are not cleared.
module reorder_buffer_queue #(
    parameter int DEPTH         = rbq_pkg::DEPTH_DEF,
    parameter int PAYLOAD_WIDTH = rbq_pkg::PAYLOAD_W_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rbq_pkg::KIND_W-1:0]   i_kind,
    input  logic [rbq_pkg::TAG_W-1:0]    i_entry_tag,
    input  logic [rbq_pkg::DATA_W-1:0]   i_inst_payload,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_status,
    output logic [rbq_pkg::TAG_W-1:0]    o_result_tag,
    output logic [rbq_pkg::DATA_W-1:0]   o_result_payload,
    output logic                         o_entry_ready,
    output logic                         o_has_space,
    output logic                         o_head_ready,
    output logic [rbq_pkg::OCC_W-1:0]    o_occupancy,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [rbq_pkg::CFG_W-1:0]    i_cfg_data
);
    import rbq_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STORE_W = (PAYLOAD_WIDTH < DATA_W) ? PAYLOAD_WIDTH : DATA_W;

    logic [CFG_W-1:0]   r_active;
    logic [CNT_W-1:0]   size;
    t_result            res;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [STORE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [STORE_W-1:0] ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_active <= i_cfg_data;
        end
    end

    always_comb begin
        priority if (r_active == '0) begin
            size = CNT_W'(1);
        end else if (int'(r_active) > DEPTH) begin
            size = CNT_W'(DEPTH);
        end else begin
            size = CNT_W'(int'(r_active));
        end
    end

    rbq_ctrl #(
        .DEPTH   (DEPTH),
        .STORE_W (STORE_W)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_size         (size),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_entry_tag    (i_entry_tag),
        .i_inst_payload (i_inst_payload),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_res          (res),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata),
        .o_ram_re       (ram_re),
        .o_ram_raddr    (ram_raddr)
    );

    rbq_ram #(
        .WIDTH (STORE_W),
        .DEPTH (DEPTH)
    ) u_payload_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_status         = res.status;
    assign o_result_tag     = res.tag;
    assign o_result_payload = res.commit ? DATA_W'(ram_rdata) : '0;
    assign o_entry_ready    = res.entry_ready;
    assign o_has_space      = res.has_space;
    assign o_head_ready     = res.head_ready;
    assign o_occupancy      = res.occupancy;

endmodule

@@ tb/reorder_buffer_queue_test.sv @@
// Self-checking bench for reorder_buffer_queue: a directed table, then random phases
// across several sizes, each result checked against the table or an in-bench buffer.
// Depends on rbq_pkg and the reorder_buffer_queue RTL only.
module reorder_buffer_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rbq_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_BEATS = 120;

    typedef struct packed {
        t_status           status;
        logic [TAG_W-1:0]  tag;
        logic [DATA_W-1:0] payload;
        logic              entry_ready;
        logic              has_space;
        logic              head_ready;
        logic [OCC_W-1:0]  occupancy;
    } t_rob_result;

    typedef struct {
        logic              is_cfg;
        logic [CFG_W-1:0]  cfg_val;
        t_kind             kind;
        logic [TAG_W-1:0]  tag;
        logic [DATA_W-1:0] payload;
        logic              fixed;
        t_rob_result       want;
    } t_plan_row;

    localparam t_rob_result NO_WANT = '{ST_OK, 5'd0, 32'd0, 1'b0, 1'b0, 1'b0, 6'd0};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [KIND_W-1:0] in_kind = '0;
    logic [TAG_W-1:0]  in_tag = '0;
    logic [DATA_W-1:0] in_payload = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        res_status;
    logic [TAG_W-1:0]  res_tag;
    logic [DATA_W-1:0] res_payload;
    logic              res_entry_ready;
    logic              res_has_space;
    logic              res_head_ready;
    logic [OCC_W-1:0]  res_occupancy;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data = '0;

    logic              gap_on = 1'b1;
    logic              stall_on = 1'b1;
    int                fail_count = 0;
    int                cycle_count = 0;

    // in-bench copy of the buffer
    logic [DATA_W-1:0] rob_data [DEPTH];
    logic              rob_valid [DEPTH];
    logic              rob_done [DEPTH];
    logic [TAG_W-1:0]  rob_head = '0;
    logic [TAG_W-1:0]  rob_tail = '0;
    int unsigned       fill_level = 0;
    logic [CFG_W-1:0]  size_reg = CFG_RESET;

    t_rob_result       pending_results [$];
    t_plan_row         plan [31];

    reorder_buffer_queue dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_kind           (in_kind),
        .i_entry_tag      (in_tag),
        .i_inst_payload   (in_payload),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (res_status),
        .o_result_tag     (res_tag),
        .o_result_payload (res_payload),
        .o_entry_ready    (res_entry_ready),
        .o_has_space      (res_has_space),
        .o_head_ready     (res_head_ready),
        .o_occupancy      (res_occupancy),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_data       (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int unsigned span_now();
        if (size_reg == 0) return 1;
        if (size_reg > DEPTH) return DEPTH;
        return size_reg;
    endfunction

    function automatic logic [TAG_W-1:0] step_ptr(input logic [TAG_W-1:0] p);
        int unsigned n;
        n = p + 1;
        if (n >= span_now() || n >= DEPTH) return '0;
        return n[TAG_W-1:0];
    endfunction

    task automatic apply_beat(input t_kind k, input logic [TAG_W-1:0] t,
                              input logic [DATA_W-1:0] p, output t_rob_result r);
        r = NO_WANT;
        case (k)
            K_ALLOC: begin
                if (fill_level >= span_now() || rob_valid[rob_tail]) begin
                    r.status = ST_FULL;
                end else begin
                    rob_data[rob_tail]  = p;
                    rob_valid[rob_tail] = 1'b1;
                    rob_done[rob_tail]  = 1'b0;
                    r.tag               = rob_tail;
                    fill_level++;
                    rob_tail            = step_ptr(rob_tail);
                end
            end
            K_COMPLETE: begin
                if (!rob_valid[t] || rob_done[t]) r.status = ST_BAD_TAG;
                else rob_done[t] = 1'b1;
            end
            K_QUERY: begin
                if (!rob_valid[t]) r.status = ST_BAD_TAG;
                else r.entry_ready = rob_done[t];
            end
            default: begin
                if (fill_level == 0 || !rob_valid[rob_head] || !rob_done[rob_head]) begin
                    r.status = ST_NOT_READY;
                end else begin
                    r.tag               = rob_head;
                    r.payload           = rob_data[rob_head];
                    rob_valid[rob_head] = 1'b0;
                    rob_done[rob_head]  = 1'b0;
                    fill_level--;
                    rob_head            = step_ptr(rob_head);
                end
            end
        endcase
        r.has_space  = fill_level < span_now();
        r.head_ready = rob_valid[rob_head] && rob_done[rob_head];
        r.occupancy  = fill_level[OCC_W-1:0];
    endtask

    task automatic send_beat(input t_kind k, input logic [TAG_W-1:0] t,
                             input logic [DATA_W-1:0] p, input logic fixed,
                             input t_rob_result want);
        t_rob_result r;
        while (gap_on && $urandom_range(0, 99) < 6) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_kind    <= k;
        in_tag     <= t;
        in_payload <= p;
        do @(posedge clk); while (!in_ready);
        apply_beat(k, t, p, r);
        pending_results.push_back(fixed ? want : r);
    endtask

    // drain, then write the size register while the block is idle
    task automatic write_size(input logic [CFG_W-1:0] v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_reg = v;
    endtask

    function automatic logic [TAG_W-1:0] pick_tag(input logic pending_only);
        int unsigned      start;
        logic [TAG_W-1:0] idx;
        start = $urandom_range(0, DEPTH - 1);
        for (int j = 0; j < DEPTH; j++) begin
            idx = TAG_W'((start + j) % DEPTH);
            if (rob_valid[idx] && (!pending_only || !rob_done[idx])) return idx;
        end
        return TAG_W'($urandom_range(0, DEPTH - 1));
    endfunction

    task automatic random_beat(input int alloc_pct);
        int                roll;
        int                pick;
        t_kind             k;
        logic [TAG_W-1:0]  t;
        logic [DATA_W-1:0] p;
        roll = $urandom_range(0, 99);
        p    = $urandom();
        t    = TAG_W'($urandom_range(0, DEPTH - 1));
        if (roll < 6) begin
            k = t_kind'($urandom_range(0, 3));
        end else if (roll < 6 + alloc_pct) begin
            k = K_ALLOC;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                k = K_COMPLETE;
                if ($urandom_range(0, 1) && rob_valid[rob_head] && !rob_done[rob_head])
                    t = rob_head;
                else if ($urandom_range(0, 9) != 0)
                    t = pick_tag(1'b1);
            end else if (pick < 65) begin
                k = K_QUERY;
                if ($urandom_range(0, 9) < 7) t = pick_tag(1'b0);
            end else begin
                k = K_COMMIT;
            end
        end
        send_beat(k, t, p, 1'b0, NO_WANT);
    endtask

    always @(posedge clk) begin
        t_rob_result got;
        t_rob_result want;
        if (rst_n && out_valid && out_ready) begin
            got.status      = t_status'(res_status);
            got.tag         = res_tag;
            got.payload     = res_payload;
            got.entry_ready = res_entry_ready;
            got.has_space   = res_has_space;
            got.head_ready  = res_head_ready;
            got.occupancy   = res_occupancy;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result beat: st=%0d tag=%0d pay=%h", got.status,
                             got.tag, got.payload);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: exp st=%0d tag=%0d pay=%h rdy=%b sp=%b hr=%b ",
                                  "occ=%0d | got st=%0d tag=%0d pay=%h rdy=%b sp=%b hr=%b ",
                                  "occ=%0d"},
                                 want.status, want.tag, want.payload, want.entry_ready,
                                 want.has_space, want.head_ready, want.occupancy,
                                 got.status, got.tag, got.payload, got.entry_ready,
                                 got.has_space, got.head_ready, got.occupancy);
                end
            end
        end
        out_ready <= !stall_on || ($urandom_range(0, 99) >= 6);
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("reorder_buffer_queue verification failed");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] phase_sizes [12];
        for (int i = 0; i < DEPTH; i++) begin
            rob_data[i]  = '0;
            rob_valid[i] = 1'b0;
            rob_done[i]  = 1'b0;
        end
        phase_sizes = '{6'd4, 6'd32, 6'd1, 6'd8, 6'd0, 6'd16, 6'd63, 6'd2, 6'd3,
                        6'd31, 6'd5, 6'd32};
        plan = '{
            '{0, 0, K_COMMIT,   0,  32'h0,
              1, '{ST_NOT_READY, 5'd0, 32'd0, 1'b0, 1'b1, 1'b0, 6'd0}},
            '{0, 0, K_QUERY,    0,  32'h0,
              1, '{ST_BAD_TAG,   5'd0, 32'd0, 1'b0, 1'b1, 1'b0, 6'd0}},
            '{0, 0, K_COMPLETE, 31, 32'h0,
              1, '{ST_BAD_TAG,   5'd0, 32'd0, 1'b0, 1'b1, 1'b0, 6'd0}},
            '{0, 0, K_ALLOC,    0,  32'hFFFF_FFFF,
              1, '{ST_OK,        5'd0, 32'd0, 1'b0, 1'b1, 1'b0, 6'd1}},
            '{0, 0, K_COMMIT,   0,  32'h0,
              1, '{ST_NOT_READY, 5'd0, 32'd0, 1'b0, 1'b1, 1'b0, 6'd1}},
            '{0, 0, K_QUERY,    0,  32'h0,
              1, '{ST_OK,        5'd0, 32'd0, 1'b0, 1'b1, 1'b0, 6'd1}},
            '{0, 0, K_COMPLETE, 0,  32'h0,
              1, '{ST_OK,        5'd0, 32'd0, 1'b0, 1'b1, 1'b1, 6'd1}},
            '{0, 0, K_COMPLETE, 0,  32'h0,
              1, '{ST_BAD_TAG,   5'd0, 32'd0, 1'b0, 1'b1, 1'b1, 6'd1}},
            '{0, 0, K_QUERY,    0,  32'h0,
              1, '{ST_OK,        5'd0, 32'd0, 1'b1, 1'b1, 1'b1, 6'd1}},
            '{0, 0, K_ALLOC,    0,  32'h0000_0000, 0, NO_WANT},
            '{0, 0, K_ALLOC,    0,  32'hA5A5_A5A5, 0, NO_WANT},
            '{0, 0, K_COMMIT,   0,  32'h0,         0, NO_WANT},
            '{0, 0, K_COMMIT,   0,  32'h0,         0, NO_WANT},
            '{0, 0, K_COMPLETE, 2,  32'h0,         0, NO_WANT},
            '{0, 0, K_COMPLETE, 1,  32'h0,         0, NO_WANT},
            '{0, 0, K_COMMIT,   0,  32'h0,         0, NO_WANT},
            '{0, 0, K_COMMIT,   0,  32'h0,         0, NO_WANT},
            '{1, 1, K_ALLOC,    0,  32'h0,         0, NO_WANT},
            '{0, 0, K_ALLOC,    0,  32'h1234_5678, 0, NO_WANT},
            '{0, 0, K_ALLOC,    0,  32'h5A5A_5A5A, 0, NO_WANT},
            '{0, 0, K_COMPLETE, 3,  32'h0,         0, NO_WANT},
            '{0, 0, K_COMMIT,   0,  32'h0,         0, NO_WANT},
            '{1, 2, K_ALLOC,    0,  32'h0,         0, NO_WANT},
            '{0, 0, K_ALLOC,    0,  32'h0000_0001, 0, NO_WANT},
            '{0, 0, K_ALLOC,    0,  32'h0000_0002, 0, NO_WANT},
            '{1, 4, K_ALLOC,    0,  32'h0,         0, NO_WANT},
            '{0, 0, K_ALLOC,    0,  32'h0000_0003, 0, NO_WANT},
            '{0, 0, K_COMPLETE, 0,  32'h0,         0, NO_WANT},
            '{0, 0, K_COMPLETE, 1,  32'h0,         0, NO_WANT},
            '{0, 0, K_COMMIT,   0,  32'h0,         0, NO_WANT},
            '{0, 0, K_COMMIT,   0,  32'h0,         0, NO_WANT}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                write_size(plan[i].cfg_val);
            else
                send_beat(plan[i].kind, plan[i].tag, plan[i].payload, plan[i].fixed,
                          plan[i].want);
        end

        foreach (phase_sizes[ph]) begin
            if (ph == 11) write_size(CFG_W'($urandom_range(1, DEPTH)));
            else write_size(phase_sizes[ph]);
            gap_on   <= (ph != 5);
            stall_on <= (ph != 5);
            for (int n = 0; n < PHASE_BEATS; n++)
                random_beat((ph % 2 == 0) ? 50 : 22);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("reorder_buffer_queue verification clean");
        else
            $display("reorder_buffer_queue verification failed");
        $finish;
    end

endmodule
